// ===== hdl/mmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmp_pkg: shared types and constants for the mixed membership predictor
// Table select codes, configuration register indexes and word types.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int WordW = 32;
  localparam int AccW  = 64;

  // table select codes
  localparam logic [2:0] TabUfac   = 3'd0;
  localparam logic [2:0] TabIfac   = 3'd1;
  localparam logic [2:0] TabUwt    = 3'd2;
  localparam logic [2:0] TabIwt    = 3'd3;
  localparam logic [2:0] TabIoff   = 3'd4;
  localparam logic [2:0] TabUoff   = 3'd5;
  localparam logic [2:0] TabGlobal = 3'd6;

  // configuration register indexes
  localparam logic [2:0] RegFactors = 3'd0;
  localparam logic [2:0] RegUtopics = 3'd1;
  localparam logic [2:0] RegItopics = 3'd2;
  localparam logic [2:0] RegSamples = 3'd3;
  localparam logic [2:0] RegEnables = 3'd4;
  localparam logic [2:0] RegGiven   = 3'd5;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [AccW-1:0]  acc_t;

endpackage

// ===== hdl/mmp_ram.sv =====
// ----------------------------------------------------------------------------
// mmp_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read each cycle.
// ----------------------------------------------------------------------------
module mmp_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mixed_membership_mf_predict_top.sv =====
// Operation: a load is written into its table at its transfer; a predict walks S samples
// of N enabled terms each (F factors, the global offset, and per offset side one term
// per topic, or one when a topic is given), then takes the average over the samples.
// One item at a time; each term passes read, multiply and accumulate steps, the average
// is a restoring divide; a held result stalls only the final write.
// Reset: control state and configuration return to their reset values; tables hold
// undefined contents until written.
// ----------------------------------------------------------------------------
// mixed_membership_mf_predict_top: fixed point mixed membership predictor
// Per-sample tables in synchronous RAMs, walked term by term by a sequencer.
// ----------------------------------------------------------------------------
module mixed_membership_mf_predict_top #(
  parameter int MAX_USERS   = 1024,
  parameter int MAX_ITEMS   = 1024,
  parameter int MAX_FACTORS = 16,
  parameter int MAX_TOPICS  = 8,
  parameter int MAX_SAMPLES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [2:0]  table_select,
  input  logic [1:0]  sample_index,
  input  logic [9:0]  row_index,
  input  logic [3:0]  column_index,
  input  logic signed [31:0] load_value,
  input  logic [9:0]  user_index,
  input  logic [9:0]  item_index,
  input  logic [2:0]  user_topic,
  input  logic [2:0]  item_topic,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] prediction,
  output logic        saturated
);
  import mmp_pkg::*;

  localparam int SW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int UFD = MAX_SAMPLES * MAX_USERS * MAX_FACTORS;
  localparam int IFD = MAX_SAMPLES * MAX_ITEMS * MAX_FACTORS;
  localparam int UTD = MAX_SAMPLES * MAX_USERS * MAX_TOPICS;
  localparam int ITD = MAX_SAMPLES * MAX_ITEMS * MAX_TOPICS;
  localparam int UFA = $clog2(UFD);
  localparam int IFA = $clog2(IFD);
  localparam int UTA = $clog2(UTD);
  localparam int ITA = $clog2(ITD);
  localparam int GD  = (MAX_SAMPLES > 1) ? MAX_SAMPLES : 2;
  localparam int GA  = $clog2(GD);
  localparam int CW  = 9;   // loop counter, wide enough for 256 factors
  localparam int DW  = AccW + 2;

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSamp  = 4'd1;
  localparam logic [3:0] StRead  = 4'd2;
  localparam logic [3:0] StWait  = 4'd3;
  localparam logic [3:0] StMul   = 4'd4;
  localparam logic [3:0] StAcc   = 4'd5;
  localparam logic [3:0] StDivPr = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;

  // term phases within one sample
  localparam logic [1:0] PhIoff = 2'd0;
  localparam logic [1:0] PhUoff = 2'd1;
  localparam logic [1:0] PhDot  = 2'd2;
  localparam logic [1:0] PhGlb  = 2'd3;

  // configuration registers
  logic [4:0] factor_count;
  logic [3:0] user_topic_count, item_topic_count;
  logic [2:0] sample_count, term_enables;
  logic       topics_given;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_count     <= '0;
      user_topic_count <= '0;
      item_topic_count <= '0;
      sample_count     <= 3'd1;
      term_enables     <= 3'd7;
      topics_given     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegFactors: factor_count     <= cfg_data;
        RegUtopics: user_topic_count <= cfg_data[3:0];
        RegItopics: item_topic_count <= cfg_data[3:0];
        RegSamples: sample_count     <= cfg_data[2:0];
        RegEnables: term_enables     <= cfg_data[2:0];
        RegGiven:   topics_given     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective counts, clipped to the table sizes; a sample count of zero counts as one
  logic [CW-1:0] nf, nu, ni, ns;
  always_comb begin
    nf = (CW'(factor_count) > CW'(MAX_FACTORS)) ? CW'(MAX_FACTORS) : CW'(factor_count);
    nu = (CW'(user_topic_count) > CW'(MAX_TOPICS)) ? CW'(MAX_TOPICS)
                                                    : CW'(user_topic_count);
    ni = (CW'(item_topic_count) > CW'(MAX_TOPICS)) ? CW'(MAX_TOPICS)
                                                    : CW'(item_topic_count);
    if (sample_count == 3'd0) ns = CW'(1);
    else if (CW'(sample_count) > CW'(MAX_SAMPLES)) ns = CW'(MAX_SAMPLES);
    else ns = CW'(sample_count);
  end

  // sequencer registers
  logic [3:0]    state;
  logic [1:0]    phase;
  logic [CW-1:0] samp, col, cnt_lim;
  logic          weighted;
  logic [9:0]    usr, itm;
  logic [2:0]    utop, itop;
  logic          usr_ok, itm_ok;
  acc_t          total;
  logic signed [2*WordW-1:0] prod;
  logic [6:0]    div_step;
  logic [DW-1:0] rem, quo, dvd;
  logic          neg;
  logic signed [DW-1:0] num;
  logic [CW-1:0] den;

  // memory ports
  logic          ld;
  logic [UFA-1:0] ufa_r;
  logic [IFA-1:0] ifa_r;
  logic [UTA-1:0] uta_r;
  logic [ITA-1:0] ita_r;
  logic [GA-1:0]  ga_r;
  logic [WordW-1:0] ufac_q, ifac_q, uwt_q, iwt_q, ioff_q, uoff_q, glb_q;
  logic          samp_ok_ld, ldu_ok, ldi_ok, ldf_ok, ldt_ok;
  logic [SW-1:0] lsmp;
  logic [UFA-1:0] ufa_w;
  logic [IFA-1:0] ifa_w;
  logic [UTA-1:0] uta_w;
  logic [ITA-1:0] ita_w;
  logic          out_free;

  // the result register parts the input from a held result
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == StIdle);
  assign ld = in_valid && in_ready && action;
  assign lsmp = SW'(sample_index);
  assign samp_ok_ld = 32'(sample_index) < 32'(MAX_SAMPLES);
  assign ldu_ok = 32'(row_index) < 32'(MAX_USERS);
  assign ldi_ok = 32'(row_index) < 32'(MAX_ITEMS);
  assign ldf_ok = 32'(column_index) < 32'(MAX_FACTORS);
  assign ldt_ok = 32'(column_index) < 32'(MAX_TOPICS);
  assign ufa_w = UFA'((32'(lsmp) * MAX_USERS + 32'(row_index)) * MAX_FACTORS
                      + 32'(column_index));
  assign ifa_w = IFA'((32'(lsmp) * MAX_ITEMS + 32'(row_index)) * MAX_FACTORS
                      + 32'(column_index));
  assign uta_w = UTA'((32'(lsmp) * MAX_USERS + 32'(row_index)) * MAX_TOPICS
                      + 32'(column_index));
  assign ita_w = ITA'((32'(lsmp) * MAX_ITEMS + 32'(row_index)) * MAX_TOPICS
                      + 32'(column_index));

  // read addresses for the current term
  logic [CW-1:0] rcol;
  logic [SW-1:0] rs;
  always_comb begin
    rs = SW'(samp);
    rcol = col;
    if (!weighted) rcol = (phase == PhIoff) ? CW'(utop) : CW'(itop);
    if (!weighted && topics_given == 1'b0) rcol = '0;
    ufa_r = UFA'((32'(rs) * MAX_USERS + 32'(usr)) * MAX_FACTORS + 32'(col));
    ifa_r = IFA'((32'(rs) * MAX_ITEMS + 32'(itm)) * MAX_FACTORS + 32'(col));
    uta_r = UTA'((32'(rs) * MAX_USERS + 32'(usr)) * MAX_TOPICS + 32'(rcol));
    ita_r = ITA'((32'(rs) * MAX_ITEMS + 32'(itm)) * MAX_TOPICS + 32'(rcol));
    ga_r  = GA'(samp);
  end

  mmp_ram #(.Width(WordW), .Depth(UFD)) u_ufac (.clk, .we(ld && table_select == TabUfac
    && samp_ok_ld && ldu_ok && ldf_ok), .waddr(ufa_w), .wdata(load_value),
    .raddr(ufa_r), .rdata(ufac_q));
  mmp_ram #(.Width(WordW), .Depth(IFD)) u_ifac (.clk, .we(ld && table_select == TabIfac
    && samp_ok_ld && ldi_ok && ldf_ok), .waddr(ifa_w), .wdata(load_value),
    .raddr(ifa_r), .rdata(ifac_q));
  mmp_ram #(.Width(WordW), .Depth(UTD)) u_uwt (.clk, .we(ld && table_select == TabUwt
    && samp_ok_ld && ldu_ok && ldt_ok), .waddr(uta_w), .wdata(load_value),
    .raddr(uta_r), .rdata(uwt_q));
  mmp_ram #(.Width(WordW), .Depth(ITD)) u_iwt (.clk, .we(ld && table_select == TabIwt
    && samp_ok_ld && ldi_ok && ldt_ok), .waddr(ita_w), .wdata(load_value),
    .raddr(ita_r), .rdata(iwt_q));
  mmp_ram #(.Width(WordW), .Depth(ITD)) u_ioff (.clk, .we(ld && table_select == TabIoff
    && samp_ok_ld && ldi_ok && ldt_ok), .waddr(ita_w), .wdata(load_value),
    .raddr(ita_r), .rdata(ioff_q));
  mmp_ram #(.Width(WordW), .Depth(UTD)) u_uoff (.clk, .we(ld && table_select == TabUoff
    && samp_ok_ld && ldu_ok && ldt_ok), .waddr(uta_w), .wdata(load_value),
    .raddr(uta_r), .rdata(uoff_q));
  mmp_ram #(.Width(WordW), .Depth(GD)) u_glb (.clk, .we(ld && table_select == TabGlobal
    && samp_ok_ld), .waddr(GA'(lsmp)), .wdata(load_value),
    .raddr(ga_r), .rdata(glb_q));

  // phase helper: does a phase contribute
  function automatic logic ph_on(input logic [1:0] ph, input logic [2:0] en,
                                 input logic [CW-1:0] cu, input logic [CW-1:0] ci);
    logic r;
    begin
      r = 1'b0;
      case (ph)
        PhIoff: r = en[2] && (cu != '0);
        PhUoff: r = en[1] && (ci != '0);
        PhDot, PhGlb: r = en[0];
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  // rounded product of two Q16.16 words
  acc_t prod_r;
  assign prod_r = (AccW'(prod) + AccW'(32768)) >>> 16;

  // selected read data
  word_t rd_a, rd_b;
  logic  rd_zero;
  always_comb begin
    rd_a = '0;
    rd_b = '0;
    rd_zero = !(usr_ok && itm_ok);
    case (phase)
      PhIoff: begin
        rd_a = ioff_q;
        rd_b = uwt_q;
        rd_zero = !itm_ok || (weighted && !usr_ok) ||
                  (!weighted && topics_given && CW'(utop) >= nu);
      end
      PhUoff: begin
        rd_a = uoff_q;
        rd_b = iwt_q;
        rd_zero = !usr_ok || (weighted && !itm_ok) ||
                  (!weighted && topics_given && CW'(itop) >= ni);
      end
      PhDot: begin
        rd_a = ufac_q;
        rd_b = ifac_q;
      end
      default: begin
        rd_a = glb_q;
        rd_zero = 1'b0;
      end
    endcase
  end

  // next phase in order; none after the global offset phase
  logic [1:0] nph;
  logic       nph_ok;
  always_comb begin
    nph = phase;
    nph_ok = 1'b0;
    if (phase != PhGlb) begin
      nph = phase + 2'd1;
      nph_ok = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      // raise the result when written, drop it once transferred
      if (state == StOut && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (in_valid && in_ready && !action) begin
            usr    <= user_index;
            itm    <= item_index;
            utop   <= user_topic;
            itop   <= item_topic;
            usr_ok <= 32'(user_index) < 32'(MAX_USERS);
            itm_ok <= 32'(item_index) < 32'(MAX_ITEMS);
            total  <= '0;
            samp   <= '0;
            state  <= StSamp;
          end
        end
        StSamp: begin
          // begin a sample at the item offset phase
          phase <= PhIoff;
          col   <= '0;
          state <= StRead;
        end
        StRead: begin
          // skip phases that add nothing
          if (!ph_on(phase, term_enables, nu, ni) ||
              (phase == PhDot && nf == '0)) begin
            if (nph_ok) begin
              phase <= nph;
            end else if (samp + CW'(1) < ns) begin
              samp  <= samp + CW'(1);
              state <= StSamp;
            end else begin
              state <= StDivPr;
            end
          end else begin
            case (phase)
              PhIoff: begin
                weighted <= !topics_given && nu > CW'(1);
                cnt_lim  <= nu;
              end
              PhUoff: begin
                weighted <= !topics_given && ni > CW'(1);
                cnt_lim  <= ni;
              end
              default: begin
                weighted <= 1'b1;
                cnt_lim  <= (phase == PhDot) ? nf : CW'(1);
              end
            endcase
            col   <= '0;
            state <= StWait;
          end
        end
        StWait: begin
          state <= StMul;
        end
        StMul: begin
          if ((phase == PhIoff || phase == PhUoff) && !weighted) begin
            total <= total + (rd_zero ? '0 : AccW'(rd_a));
            col   <= cnt_lim;
          end else if (phase == PhGlb) begin
            total <= total + AccW'(rd_a);
            col   <= cnt_lim;
          end else begin
            prod  <= rd_zero ? (2*WordW)'(0) : rd_a * rd_b;
            col   <= col + CW'(1);
          end
          state <= StAcc;
        end
        StAcc: begin
          if ((phase == PhIoff || phase == PhUoff) && !weighted) begin
          end else if (phase != PhGlb) begin
            total <= total + prod_r;
          end
          if (col < cnt_lim) begin
            // read address follows col; StWait lets the data arrive
            state <= StWait;
          end else if (nph_ok) begin
            phase <= nph;
            col   <= '0;
            state <= StRead;
          end else if (samp + CW'(1) < ns) begin
            samp  <= samp + CW'(1);
            state <= StSamp;
          end else begin
            state <= StDivPr;
          end
        end
        StDivPr: begin
          // floor((2*total + ns) / (2*ns)) by restoring division on magnitude
          num      <= (DW'(total) <<< 1) + DW'(ns);
          den      <= ns << 1;
          state    <= StDiv;
          div_step <= '0;
          rem      <= '0;
        end
        StDiv: begin
          if (div_step == 7'd0) begin
            neg <= num[DW-1];
            dvd <= num[DW-1] ? DW'(-num) : DW'(num);
            quo <= '0;
            div_step <= 7'd1;
          end else if (div_step <= 7'(DW)) begin
            if ({rem[DW-2:0], dvd[DW-1]} >= DW'(den)) begin
              rem <= {rem[DW-2:0], dvd[DW-1]} - DW'(den);
              quo <= {quo[DW-2:0], 1'b1};
            end else begin
              rem <= {rem[DW-2:0], dvd[DW-1]};
              quo <= {quo[DW-2:0], 1'b0};
            end
            dvd <= dvd << 1;
            div_step <= div_step + 7'd1;
          end else begin
            state <= StOut;
          end
        end
        StOut: begin
          logic signed [DW:0] q;
          q = neg ? -$signed({1'b0, quo}) - ((rem != '0) ? (DW+1)'(1) : '0)
                  : $signed({1'b0, quo});
          // hold until the result register is free
          if (out_free) begin
            if (q > (DW+1)'(64'sd2147483647)) begin
              prediction <= 32'sh7fffffff;
              saturated  <= 1'b1;
            end else if (q < -(DW+1)'(64'sd2147483648)) begin
              prediction <= 32'sh80000000;
              saturated  <= 1'b1;
            end else begin
              prediction <= q[31:0];
              saturated  <= 1'b0;
            end
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule
